/* rtl/core/esb_pkg.sv */
// ----------------------------------------------------------------------------
// esb_pkg
// Shared types, constants and the sort microprogram of the exchange sort
// buffer.
// ----------------------------------------------------------------------------
package esb_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int STEP_W      = 3;

    // Function codes of an input transaction
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] item_value;
        logic                     final_load;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_value;
        logic                     set_empty;
        logic                     overflowed;
    } out_item_t;

    typedef logic [STEP_W-1:0] step_t;

    // Program step addresses
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_SORT  = 3'd1;
    localparam step_t STEP_OUTER = 3'd2;
    localparam step_t STEP_LATCH = 3'd3;
    localparam step_t STEP_CMP   = 3'd4;
    localparam step_t STEP_WRI   = 3'd5;
    localparam step_t STEP_FRD   = 3'd6;
    localparam step_t STEP_FOUT  = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_IDLE      = 3'd0,  // take a transaction, store loads
        OP_CLR_I     = 3'd1,  // outer index to zero
        OP_RD_I      = 3'd2,  // read store[i], j = i + 1
        OP_LATCH_I   = 3'd3,  // hold store[i], read store[j]
        OP_CMP       = 3'd4,  // compare, swap, advance j
        OP_WR_I      = 3'd5,  // write back store[i], advance i
        OP_FETCH_RD  = 3'd6,  // read store[fetch_position]
        OP_FETCH_OUT = 3'd7   // load the result register
    } op_t;

    // Sequencer jump conditions
    typedef enum logic [2:0] {
        CND_NEXT     = 3'd0,
        CND_JUMP     = 3'd1,
        CND_DISPATCH = 3'd2,
        CND_I_DONE   = 3'd3,
        CND_J_MORE   = 3'd4,
        CND_OUT_WAIT = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic is_fetch;
        logic is_final;
        logic i_done;
        logic j_more;
        logic out_free;
    } seq_status_t;

    // Microprogram ROM
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        begin
            unique case (step)
                STEP_IDLE:  w = '{op: OP_IDLE,      cond: CND_DISPATCH, target: STEP_SORT};
                STEP_SORT:  w = '{op: OP_CLR_I,     cond: CND_NEXT,     target: STEP_IDLE};
                STEP_OUTER: w = '{op: OP_RD_I,      cond: CND_I_DONE,   target: STEP_IDLE};
                STEP_LATCH: w = '{op: OP_LATCH_I,   cond: CND_NEXT,     target: STEP_IDLE};
                STEP_CMP:   w = '{op: OP_CMP,       cond: CND_J_MORE,   target: STEP_CMP};
                STEP_WRI:   w = '{op: OP_WR_I,      cond: CND_JUMP,     target: STEP_OUTER};
                STEP_FRD:   w = '{op: OP_FETCH_RD,  cond: CND_NEXT,     target: STEP_IDLE};
                STEP_FOUT:  w = '{op: OP_FETCH_OUT, cond: CND_OUT_WAIT, target: STEP_IDLE};
                default:    w = '{op: OP_IDLE,      cond: CND_JUMP,     target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/core/esb_if.sv */
// ----------------------------------------------------------------------------
// esb_in_if / esb_out_if
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface esb_in_if;
    logic              valid;
    logic              ready;
    esb_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esb_out_if;
    logic               valid;
    logic               ready;
    esb_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/esb_seq.sv */
// ----------------------------------------------------------------------------
// esb_seq
// Step counter and jump logic over the microprogram ROM.
// ----------------------------------------------------------------------------
module esb_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esb_pkg::seq_status_t status,
    output esb_pkg::ctrl_word_t  ctrl
);

    esb_pkg::step_t pc_reg;
    esb_pkg::step_t pc_next;
    esb_pkg::step_t pc_inc;

    // Fetch the current control word
    assign ctrl   = esb_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + esb_pkg::STEP_W'(1);

    // Resolve the next step
    always_comb
    begin
        unique case (ctrl.cond)
            esb_pkg::CND_NEXT:     pc_next = pc_inc;
            esb_pkg::CND_JUMP:     pc_next = ctrl.target;
            esb_pkg::CND_DISPATCH:
            begin
                if (status.accept && status.is_fetch)
                    pc_next = esb_pkg::STEP_FRD;
                else if (status.accept && status.is_final)
                    pc_next = ctrl.target;
                else
                    pc_next = pc_reg;
            end
            esb_pkg::CND_I_DONE:   pc_next = status.i_done ? ctrl.target : pc_inc;
            esb_pkg::CND_J_MORE:   pc_next = status.j_more ? ctrl.target : pc_inc;
            esb_pkg::CND_OUT_WAIT: pc_next = status.out_free ? ctrl.target : pc_reg;
            default:               pc_next = esb_pkg::STEP_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= esb_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

/* rtl/core/exchange_sort_buffer.sv */
// ----------------------------------------------------------------------------
// exchange_sort_buffer
// Loads a set of signed values, sorts it in place and returns it in order.
// ----------------------------------------------------------------------------
// A load is stored in the idle step, which stays ready for the next one. A
// load with final_load set closes the set and starts an exchange sort over
// the n stored values; no transaction is taken until it finishes. The sort
// time is set by the compare loop: one compare-and-swap per cycle through
// the single read port of the value memory, with store[i] held in a register
// across the inner loop. A fetch transaction runs through dispatch, memory
// read and result load, and takes longer while the result register is still
// waiting to be taken. Loads past the store depth are dropped and flagged in
// every later result of the set. The value memory needs no clearing after
// reset.
module exchange_sort_buffer (
    input  logic             clk,
    input  logic             rst_n,
    esb_in_if.sink           in_ch,
    esb_out_if.source        out_ch
);

    localparam int ADDR_W = esb_pkg::ADDR_W;
    localparam int CNT_W  = esb_pkg::CNT_W;
    localparam int DATA_W = esb_pkg::DATA_W;

    esb_pkg::ctrl_word_t  ctrl;
    esb_pkg::seq_status_t status;

    // Value memory
    logic signed [DATA_W-1:0] mem [esb_pkg::STORE_DEPTH];
    logic signed [DATA_W-1:0] mem_rdata_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_wdata;

    // Control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fetch_pos_reg, fetch_pos_next;
    logic             ovf_reg, ovf_next;
    logic             closed_reg, closed_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    logic signed [DATA_W-1:0] vi_reg, vi_next;
    esb_pkg::out_item_t       out_data_reg, out_data_next;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] load_count;
    logic             fetch_empty;

    // Sequencer
    esb_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Handshake and sequencer status
    assign in_ch.ready  = (ctrl.op == esb_pkg::OP_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign status.accept   = accept;
    assign status.is_fetch = (in_ch.data.func == esb_pkg::FUNC_FETCH);
    assign status.is_final = in_ch.data.final_load;
    assign status.i_done   = ({1'b0, i_reg} + (CNT_W + 1)'(1)) >= {1'b0, count_reg};
    assign status.j_more   = ({1'b0, j_reg} + (CNT_W + 1)'(1)) < {1'b0, count_reg};
    assign status.out_free = out_free;

    // A load after a closed set starts a new set
    assign load_count  = closed_reg ? '0 : count_reg;
    assign fetch_empty = !closed_reg || (fetch_pos_reg >= count_reg);

    // Datapath driven by the control word
    always_comb
    begin
        count_next     = count_reg;
        fetch_pos_next = fetch_pos_reg;
        ovf_next       = ovf_reg;
        closed_next    = closed_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        vi_next        = vi_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = i_reg[ADDR_W-1:0];
        mem_raddr      = i_reg[ADDR_W-1:0];
        mem_wdata      = vi_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (ctrl.op)
            esb_pkg::OP_IDLE:
            begin
                if (accept && in_ch.data.func == esb_pkg::FUNC_LOAD)
                begin
                    ovf_next       = closed_reg ? 1'b0 : ovf_reg;
                    fetch_pos_next = closed_reg ? '0 : fetch_pos_reg;
                    closed_next    = 1'b0;
                    count_next     = load_count;
                    if (load_count < CNT_W'(esb_pkg::STORE_DEPTH))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = load_count[ADDR_W-1:0];
                        mem_wdata  = in_ch.data.item_value;
                        count_next = load_count + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.data.final_load)
                    begin
                        fetch_pos_next = '0;
                        closed_next    = 1'b1;
                    end
                end
            end
            esb_pkg::OP_CLR_I:
            begin
                i_next = '0;
            end
            esb_pkg::OP_RD_I:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg[ADDR_W-1:0];
                j_next    = i_reg + CNT_W'(1);
            end
            esb_pkg::OP_LATCH_I:
            begin
                vi_next   = mem_rdata_reg;
                mem_re    = 1'b1;
                mem_raddr = j_reg[ADDR_W-1:0];
            end
            esb_pkg::OP_CMP:
            begin
                // Read ahead at j + 1 while store[j] is compared
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(j_reg + CNT_W'(1));
                if (vi_reg > mem_rdata_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[ADDR_W-1:0];
                    mem_wdata = vi_reg;
                    vi_next   = mem_rdata_reg;
                end
                j_next = j_reg + CNT_W'(1);
            end
            esb_pkg::OP_WR_I:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[ADDR_W-1:0];
                mem_wdata = vi_reg;
                i_next    = i_reg + CNT_W'(1);
            end
            esb_pkg::OP_FETCH_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = fetch_pos_reg[ADDR_W-1:0];
            end
            esb_pkg::OP_FETCH_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.overflowed = ovf_reg;
                    out_data_next.set_empty  = fetch_empty;
                    if (fetch_empty)
                    begin
                        out_data_next.sorted_value = '0;
                        out_data_next.final_value  = 1'b0;
                    end
                    else
                    begin
                        out_data_next.sorted_value = mem_rdata_reg;
                        out_data_next.final_value  =
                            ((fetch_pos_reg + CNT_W'(1)) == count_reg);
                        fetch_pos_next = fetch_pos_reg + CNT_W'(1);
                    end
                end
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vi_reg       <= vi_next;
        out_data_reg <= out_data_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fetch_pos_reg <= '0;
            ovf_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fetch_pos_reg <= fetch_pos_next;
            ovf_reg       <= ovf_next;
            closed_reg    <= closed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stored count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(esb_pkg::STORE_DEPTH))
        else $error("stored count beyond store depth");

    // Inner loop index stays inside the set
    a_j_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == esb_pkg::OP_CMP) |-> (j_reg < count_reg))
        else $error("compare index outside the set");

    // A result appears only from the result load step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == esb_pkg::OP_FETCH_OUT))
        else $error("result raised outside the fetch step");

    // A plain load leaves the sequencer waiting for the next transaction
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.data.func == esb_pkg::FUNC_LOAD && !in_ch.data.final_load)
        |=> (ctrl.op == esb_pkg::OP_IDLE))
        else $error("plain load left the idle step");

endmodule
